### design/epqt_pkg.sv
package epqt_pkg;

   localparam int ADC_BITS       = 12;
   localparam int VALUE_BITS     = 16;
   localparam int STEP_BITS      = VALUE_BITS - 1;
   localparam int CSR_DATA_BITS  = (VALUE_BITS > ADC_BITS) ? VALUE_BITS : ADC_BITS;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [ADC_BITS-1:0]          adc_type;
   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [STEP_BITS-1:0]         step_type;
   typedef logic [CSR_DATA_BITS-1:0]     csr_data_type;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_SEED   = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      QUAD_1 = 2'd0,
      QUAD_2 = 2'd1,
      QUAD_3 = 2'd2,
      QUAD_4 = 2'd3
   } quad_type;

   typedef enum logic [1:0] {
      STATUS_STEPPED = 2'd0,
      STATUS_IGNORED = 2'd1,
      STATUS_SEEDED  = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ADC1_SPLIT     = 3'd0,
      CSR_ADC2_SPLIT     = 3'd1,
      CSR_ADC1_DEADBAND  = 3'd2,
      CSR_ADC2_DEADBAND  = 3'd3,
      CSR_VALUE_FLOOR    = 3'd4,
      CSR_VALUE_CEILING  = 3'd5,
      CSR_VALUE_STEP     = 3'd6,
      CSR_SEED_POSITION  = 3'd7
   } csr_index_type;

   localparam adc_type   ADC_SPLIT_RESET     = adc_type'((1 << (ADC_BITS - 1)) - 1);
   localparam adc_type   DEADBAND_RESET      = '0;
   localparam value_type VALUE_FLOOR_RESET   = '0;
   localparam value_type VALUE_CEILING_RESET = value_type'(1000);
   localparam step_type  VALUE_STEP_RESET    = step_type'(1);
   localparam value_type SEED_POSITION_RESET = '0;

   typedef struct packed {
      adc_type   adc1_split;
      adc_type   adc2_split;
      adc_type   adc1_deadband;
      adc_type   adc2_deadband;
      value_type value_floor;
      value_type value_ceiling;
      step_type  value_step;
      value_type seed_position;
   } cfg_type;

   typedef struct packed {
      value_type position;
      adc_type   last_adc1;
      adc_type   last_adc2;
      quad_type  previous_quadrant;
   } track_state_type;

   typedef struct packed {
      kind_type kind;
      adc_type  adc1_sample;
      adc_type  adc2_sample;
   } req_item_type;

endpackage

### design/epqt_req_if.sv
interface epqt_req_if;
   import epqt_pkg::*;

   logic    valid;
   logic    ready;
   logic    kind;
   adc_type adc1_sample;
   adc_type adc2_sample;

   modport source (output valid, output kind, output adc1_sample, output adc2_sample,
                   input ready);
   modport sink (input valid, input kind, input adc1_sample, input adc2_sample,
                 output ready);
endinterface

### design/epqt_rsp_if.sv
interface epqt_rsp_if;
   import epqt_pkg::*;

   logic       valid;
   logic       ready;
   value_type  position_out;
   logic [1:0] status;

   modport source (output valid, output position_out, output status, input ready);
   modport sink (input valid, input position_out, input status, output ready);
endinterface

### design/epqt_step.sv
module epqt_step (
   input  epqt_pkg::cfg_type         cfg,
   input  epqt_pkg::track_state_type state_cur,
   input  epqt_pkg::req_item_type    item,
   output epqt_pkg::track_state_type state_next,
   output epqt_pkg::status_type      status
);
   import epqt_pkg::*;

   localparam int DZ_BITS  = ADC_BITS + 2;
   localparam int SUM_BITS = VALUE_BITS + 2;

   function automatic logic in_deadband(adc_type r, adc_type last, adc_type dz);
      logic signed [DZ_BITS-1:0] x;
      logic signed [DZ_BITS-1:0] l;
      logic signed [DZ_BITS-1:0] d;
      logic signed [DZ_BITS-1:0] lo;
      logic signed [DZ_BITS-1:0] hi;
      x  = signed'({2'b00, r});
      l  = signed'({2'b00, last});
      d  = signed'({2'b00, dz});
      lo = l - d;
      hi = l + d;
      return (x > lo) && (x < hi);
   endfunction

   quad_type                    quad;
   logic                        ctrl_adc2;
   adc_type                     reading;
   adc_type                     last_reading;
   adc_type                     band;
   logic                        ignored;
   logic                        rose;
   logic                        up;
   logic signed [SUM_BITS-1:0]  pos_x;
   logic signed [SUM_BITS-1:0]  step_x;
   logic signed [SUM_BITS-1:0]  floor_x;
   logic signed [SUM_BITS-1:0]  ceil_x;
   logic signed [SUM_BITS-1:0]  up_sum;
   logic signed [SUM_BITS-1:0]  down_sum;
   value_type                   pos_up;
   value_type                   pos_down;

   always_comb begin
      if (item.adc1_sample <= cfg.adc1_split && item.adc2_sample >= cfg.adc2_split) begin
         quad = QUAD_1;
      end else if (item.adc1_sample >= cfg.adc1_split
                   && item.adc2_sample >= cfg.adc2_split) begin
         quad = QUAD_2;
      end else if (item.adc1_sample >= cfg.adc1_split
                   && item.adc2_sample <= cfg.adc2_split) begin
         quad = QUAD_3;
      end else begin
         quad = QUAD_4;
      end
   end

   assign ctrl_adc2    = (quad == QUAD_1) || (quad == QUAD_4);
   assign reading      = ctrl_adc2 ? item.adc2_sample : item.adc1_sample;
   assign last_reading = ctrl_adc2 ? state_cur.last_adc2 : state_cur.last_adc1;
   assign band         = ctrl_adc2 ? cfg.adc2_deadband : cfg.adc1_deadband;
   assign ignored      = in_deadband(reading, last_reading, band);
   assign rose         = reading > last_reading;

   always_comb begin
      case (quad)
         QUAD_1:  up = rose || (state_cur.previous_quadrant == QUAD_4);
         QUAD_2:  up = rose || (state_cur.previous_quadrant == QUAD_1);
         QUAD_3:  up = !rose || (state_cur.previous_quadrant == QUAD_2);
         default: up = rose || (state_cur.previous_quadrant == QUAD_3);
      endcase
   end

   assign pos_x    = SUM_BITS'(state_cur.position);
   assign floor_x  = SUM_BITS'(cfg.value_floor);
   assign ceil_x   = SUM_BITS'(cfg.value_ceiling);
   assign step_x   = signed'({3'b000, cfg.value_step});
   assign up_sum   = pos_x + step_x;
   assign down_sum = pos_x - step_x;

   always_comb begin
      pos_up = state_cur.position;
      if (state_cur.position < cfg.value_ceiling) begin
         pos_up = (up_sum > ceil_x) ? cfg.value_ceiling : up_sum[VALUE_BITS-1:0];
      end
      pos_down = state_cur.position;
      if (state_cur.position > cfg.value_floor) begin
         pos_down = (down_sum < floor_x) ? cfg.value_floor : down_sum[VALUE_BITS-1:0];
      end
   end

   always_comb begin
      state_next = state_cur;
      if (item.kind == KIND_SEED) begin
         state_next.last_adc1 = item.adc1_sample;
         state_next.last_adc2 = item.adc2_sample;
         state_next.position  = cfg.seed_position;
         status               = STATUS_SEEDED;
      end else if (ignored) begin
         status = STATUS_IGNORED;
      end else begin
         state_next.position          = up ? pos_up : pos_down;
         state_next.last_adc1         = item.adc1_sample;
         state_next.last_adc2         = item.adc2_sample;
         state_next.previous_quadrant = quad;
         status                       = STATUS_STEPPED;
      end
   end

endmodule

### design/endless_pot_quadrant_tracker.sv
// Channel   Direction  Carries
// req_chan  in         kind, adc1_sample, adc2_sample
// rsp_chan  out        position_out, status
// csr_*     in         csr_write_en, csr_index, csr_write_data
//
// An item is registered on acceptance, and its result is then registered in the
// result register; one item can be accepted in every cycle while it does not stall.
// The tracking state is updated when an item moves into the result register.
// A stalled result register holds the input register, which then stops taking items.
// Reset is synchronous and restores the configuration registers, the valid flags and
// the tracking state to their defaults.
module endless_pot_quadrant_tracker (
   input  logic                           clock,
   input  logic                           reset,
   epqt_req_if.sink                       req_chan,
   epqt_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_en,
   input  logic [epqt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  epqt_pkg::csr_data_type         csr_write_data
);
   import epqt_pkg::*;

   cfg_type          cfg_ff;
   track_state_type  state_ff;
   track_state_type  state_in;
   logic             in_valid_ff;
   req_item_type     in_item_ff;
   logic             out_valid_ff;
   value_type        out_position_ff;
   status_type       out_status_ff;
   status_type       step_status;
   logic             advance;
   logic             take;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.adc1_split     <= ADC_SPLIT_RESET;
         cfg_ff.adc2_split     <= ADC_SPLIT_RESET;
         cfg_ff.adc1_deadband  <= DEADBAND_RESET;
         cfg_ff.adc2_deadband  <= DEADBAND_RESET;
         cfg_ff.value_floor    <= VALUE_FLOOR_RESET;
         cfg_ff.value_ceiling  <= VALUE_CEILING_RESET;
         cfg_ff.value_step     <= VALUE_STEP_RESET;
         cfg_ff.seed_position  <= SEED_POSITION_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ADC1_SPLIT:     cfg_ff.adc1_split     <= csr_write_data[ADC_BITS-1:0];
            CSR_ADC2_SPLIT:     cfg_ff.adc2_split     <= csr_write_data[ADC_BITS-1:0];
            CSR_ADC1_DEADBAND:  cfg_ff.adc1_deadband  <= csr_write_data[ADC_BITS-1:0];
            CSR_ADC2_DEADBAND:  cfg_ff.adc2_deadband  <= csr_write_data[ADC_BITS-1:0];
            CSR_VALUE_FLOOR:    cfg_ff.value_floor    <= csr_write_data[VALUE_BITS-1:0];
            CSR_VALUE_CEILING:  cfg_ff.value_ceiling  <= csr_write_data[VALUE_BITS-1:0];
            CSR_VALUE_STEP:     cfg_ff.value_step     <= csr_write_data[STEP_BITS-1:0];
            CSR_SEED_POSITION:  cfg_ff.seed_position  <= csr_write_data[VALUE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.kind        <= kind_type'(req_chan.kind);
         in_item_ff.adc1_sample <= req_chan.adc1_sample;
         in_item_ff.adc2_sample <= req_chan.adc2_sample;
      end
   end

   epqt_step u_step (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .item       (in_item_ff),
      .state_next (state_in),
      .status     (step_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.position          <= '0;
         state_ff.last_adc1         <= '0;
         state_ff.last_adc2         <= '0;
         state_ff.previous_quadrant <= QUAD_1;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_chan.ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_position_ff <= state_in.position;
         out_status_ff   <= step_status;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.position_out = out_position_ff;
   assign rsp_chan.status       = out_status_ff;

endmodule

### bench/epqt_track_checker.sv
module epqt_track_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   epqt_req_if                                  req_mon,
   epqt_rsp_if                                  rsp_mon,
   input  logic                                 csr_write_en,
   input  logic [epqt_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  epqt_pkg::csr_data_type               csr_write_data,
   output int                                   mismatches,
   output int                                   pending_results
);
   import epqt_pkg::*;

   typedef struct {
      value_type  position;
      status_type status;
   } tracked_result_type;

   cfg_type            regs;
   track_state_type    trk;
   tracked_result_type expected_positions[$];
   int                 results_seen;

   task automatic report_mismatch(string what, int got, int want);
      $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
      mismatches++;
   endtask

   function automatic logic within_band(adc_type reading, adc_type last, adc_type half_width);
      int r = reading;
      int l = last;
      int d = half_width;
      return (r > l - d) && (r < l + d);
   endfunction

   function automatic tracked_result_type advance_tracker(kind_type kind, adc_type a1,
                                                          adc_type a2);
      quad_type           quad;
      logic               ignored;
      logic               up;
      int                 pos;
      int                 lim;
      tracked_result_type res;
      res.status = STATUS_STEPPED;
      if (kind == KIND_SEED) begin
         trk.last_adc1 = a1;
         trk.last_adc2 = a2;
         trk.position  = regs.seed_position;
         res.status    = STATUS_SEEDED;
      end else begin
         if (a1 <= regs.adc1_split && a2 >= regs.adc2_split) quad = QUAD_1;
         else if (a1 >= regs.adc1_split && a2 >= regs.adc2_split) quad = QUAD_2;
         else if (a1 >= regs.adc1_split && a2 <= regs.adc2_split) quad = QUAD_3;
         else quad = QUAD_4;
         if (quad == QUAD_1 || quad == QUAD_4)
            ignored = within_band(a2, trk.last_adc2, regs.adc2_deadband);
         else
            ignored = within_band(a1, trk.last_adc1, regs.adc1_deadband);
         if (ignored) begin
            res.status = STATUS_IGNORED;
         end else begin
            case (quad)
               QUAD_1: up = (a2 > trk.last_adc2) || trk.previous_quadrant == QUAD_4;
               QUAD_2: up = (a1 > trk.last_adc1) || trk.previous_quadrant == QUAD_1;
               QUAD_3: up = !(a1 > trk.last_adc1) || trk.previous_quadrant == QUAD_2;
               default: up = (a2 > trk.last_adc2) || trk.previous_quadrant == QUAD_3;
            endcase
            pos = trk.position;
            if (up) begin
               lim = regs.value_ceiling;
               if (pos < lim) pos = (pos + int'(regs.value_step) > lim) ? lim
                                    : pos + int'(regs.value_step);
            end else begin
               lim = regs.value_floor;
               if (pos > lim) pos = (pos - int'(regs.value_step) < lim) ? lim
                                    : pos - int'(regs.value_step);
            end
            trk.position          = value_type'(pos);
            trk.previous_quadrant = quad;
            trk.last_adc1         = a1;
            trk.last_adc2         = a2;
         end
      end
      res.position = trk.position;
      return res;
   endfunction

   always @(posedge clock) begin
      tracked_result_type want;
      if (reset) begin
         regs.adc1_split     = ADC_SPLIT_RESET;
         regs.adc2_split     = ADC_SPLIT_RESET;
         regs.adc1_deadband  = DEADBAND_RESET;
         regs.adc2_deadband  = DEADBAND_RESET;
         regs.value_floor    = VALUE_FLOOR_RESET;
         regs.value_ceiling  = VALUE_CEILING_RESET;
         regs.value_step     = VALUE_STEP_RESET;
         regs.seed_position  = SEED_POSITION_RESET;
         trk = '0;
         expected_positions.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_positions.size() == 0) begin
               report_mismatch("unexpected item, position", int'(rsp_mon.position_out), 0);
            end else begin
               want = expected_positions.pop_front();
               if (rsp_mon.position_out !== want.position)
                  report_mismatch("position", int'(rsp_mon.position_out), int'(want.position));
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", int'(rsp_mon.status), int'(want.status));
            end
            results_seen++;
         end
         if (req_mon.valid && req_mon.ready)
            expected_positions.push_back(advance_tracker(kind_type'(req_mon.kind),
                                                         req_mon.adc1_sample,
                                                         req_mon.adc2_sample));
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_ADC1_SPLIT:     regs.adc1_split     = adc_type'(csr_write_data);
               CSR_ADC2_SPLIT:     regs.adc2_split     = adc_type'(csr_write_data);
               CSR_ADC1_DEADBAND:  regs.adc1_deadband  = adc_type'(csr_write_data);
               CSR_ADC2_DEADBAND:  regs.adc2_deadband  = adc_type'(csr_write_data);
               CSR_VALUE_FLOOR:    regs.value_floor    = value_type'(csr_write_data);
               CSR_VALUE_CEILING:  regs.value_ceiling  = value_type'(csr_write_data);
               CSR_VALUE_STEP:     regs.value_step     = step_type'(csr_write_data);
               CSR_SEED_POSITION:  regs.seed_position  = value_type'(csr_write_data);
               default: ;
            endcase
         end
      end
      pending_results <= expected_positions.size();
   end

endmodule

### bench/tb_endless_pot_quadrant_tracker.sv
module tb_endless_pot_quadrant_tracker;
   import epqt_pkg::*;

   localparam int STALL_LIMIT = 1000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   csr_data_type              csr_write_data;
   int                        mismatches;
   int                        pending_results;
   int                        stall_cycles;
   int                        results_taken;
   bit                        burst_mode;
   bit                        held_off;
   int                        angle = 0;
   int                        speed = 120;
   int                        direction = 1;

   epqt_req_if req_chan ();
   epqt_rsp_if rsp_chan ();

   endless_pot_quadrant_tracker uut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   epqt_track_checker track_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .mismatches      (mismatches),
      .pending_results (pending_results)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[endless_pot_quadrant_tracker] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = burst_mode ? 0 : $urandom_range(0, 3);
         if (!held_off && results_taken >= 250) begin
            gap      = 40;
            held_off = 1'b1;
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         results_taken++;
      end
   end

   task automatic offer_item(kind_type kind, adc_type a1, adc_type a2);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.kind        <= kind;
      req_chan.adc1_sample <= a1;
      req_chan.adc2_sample <= a2;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reg(csr_index_type idx, csr_data_type data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(adc_type s1, adc_type s2, adc_type dz1, adc_type dz2,
                               value_type floor_v, value_type ceiling_v, step_type step_v,
                               value_type start_v);
      set_reg(CSR_ADC1_SPLIT, csr_data_type'(s1));
      set_reg(CSR_ADC2_SPLIT, csr_data_type'(s2));
      set_reg(CSR_ADC1_DEADBAND, csr_data_type'(dz1));
      set_reg(CSR_ADC2_DEADBAND, csr_data_type'(dz2));
      set_reg(CSR_VALUE_FLOOR, csr_data_type'(floor_v));
      set_reg(CSR_VALUE_CEILING, csr_data_type'(ceiling_v));
      set_reg(CSR_VALUE_STEP, csr_data_type'(step_v));
      set_reg(CSR_SEED_POSITION, csr_data_type'(start_v));
      csr_write_en <= 1'b0;
   endtask

   // Two wipers are triangle waves a quarter turn apart over a 16384 step turn.
   function automatic adc_type wiper_reading(int phase);
      int q = phase & 16383;
      int r = (q < 8192) ? (q >> 1) : ((16383 - q) >> 1);
      r = r + int'($urandom_range(0, 8)) - 4;
      if (r < 0) r = 0;
      if (r > 4095) r = 4095;
      return adc_type'(r);
   endfunction

   task automatic run_random(int count);
      int       pick;
      kind_type kind;
      adc_type  a1;
      adc_type  a2;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         kind = KIND_SAMPLE;
         if (pick < 15) begin
            a1 = adc_type'($urandom_range(0, 4095));
            a2 = adc_type'($urandom_range(0, 4095));
            if (pick < 6) kind = KIND_SEED;
         end else begin
            if ($urandom_range(0, 15) == 0) begin
               direction = -direction;
               speed     = $urandom_range(1, 700);
            end
            angle = (angle + direction * speed) & 16383;
            a1    = wiper_reading(angle);
            a2    = wiper_reading(angle + 4096);
            if (pick < 20) kind = KIND_SEED;
         end
         offer_item(kind, a1, a2);
      end
   endtask

   initial begin
      int lo;
      int hi;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.kind        <= KIND_SAMPLE;
      req_chan.adc1_sample <= '0;
      req_chan.adc2_sample <= '0;
      csr_write_en         <= 1'b0;
      csr_index            <= CSR_ADC1_SPLIT;
      csr_write_data       <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk all four quadrants at the reset settings, including readings on the splits.
      offer_item(KIND_SAMPLE, 12'd0, 12'd0);
      offer_item(KIND_SEED, 12'd4095, 12'd4095);
      offer_item(KIND_SAMPLE, 12'd2047, 12'd2047);
      offer_item(KIND_SAMPLE, 12'd4095, 12'd2047);
      offer_item(KIND_SAMPLE, 12'd4095, 12'd0);
      offer_item(KIND_SAMPLE, 12'd0, 12'd0);
      offer_item(KIND_SAMPLE, 12'd0, 12'd4095);
      offer_item(KIND_SAMPLE, 12'd2048, 12'd2048);
      offer_item(KIND_SAMPLE, 12'd2048, 12'd2046);
      offer_item(KIND_SAMPLE, 12'd2046, 12'd2046);
      offer_item(KIND_SAMPLE, 12'd2046, 12'd1000);
      offer_item(KIND_SAMPLE, 12'd1000, 12'd2500);
      offer_item(KIND_SAMPLE, 12'd3000, 12'd3000);
      offer_item(KIND_SAMPLE, 12'd2500, 12'd3000);
      offer_item(KIND_SAMPLE, 12'd3500, 12'd100);
      offer_item(KIND_SAMPLE, 12'd100, 12'd100);
      run_random(50);
      settle();

      program_regs(12'd1500, 12'd2500, 12'd100, 12'd100, value_type'(-500),
                   value_type'(500), 15'd37, value_type'(250));
      // Readings just inside and exactly on the edge of the ADC2 dead zone, then inside the ADC1 one.
      offer_item(KIND_SEED, 12'd1000, 12'd3000);
      offer_item(KIND_SAMPLE, 12'd1000, 12'd3099);
      offer_item(KIND_SAMPLE, 12'd1000, 12'd3100);
      offer_item(KIND_SAMPLE, 12'd1000, 12'd3000);
      offer_item(KIND_SAMPLE, 12'd2000, 12'd3000);
      offer_item(KIND_SAMPLE, 12'd2050, 12'd3000);
      run_random(60);
      settle();

      program_regs(12'd0, 12'd4095, 12'd4095, 12'd4095, value_type'(-32768),
                   value_type'(32767), 15'd32767, value_type'(-32768));
      run_random(50);
      settle();

      // Floor above the ceiling.
      program_regs(12'd4095, 12'd0, 12'd0, 12'd0, value_type'(100), value_type'(-100),
                   15'd7, value_type'(0));
      run_random(50);
      settle();

      burst_mode = 1'b1;
      program_regs(12'd2047, 12'd2047, 12'd0, 12'd0, value_type'(5), value_type'(5),
                   15'd0, value_type'(32767));
      run_random(40);
      settle();
      burst_mode = 1'b0;

      repeat (3) begin
         lo = $urandom_range(0, 3000);
         hi = $urandom_range(0, 3000);
         program_regs(adc_type'($urandom_range(1000, 3000)),
                      adc_type'($urandom_range(1000, 3000)),
                      adc_type'($urandom_range(0, 200)), adc_type'($urandom_range(0, 200)),
                      value_type'(-lo), value_type'(hi), step_type'($urandom_range(1, 300)),
                      value_type'($urandom_range(0, 65535)));
         run_random(50);
         settle();
      end

      if (mismatches == 0)
         $display("[endless_pot_quadrant_tracker] OK");
      else
         $display("[endless_pot_quadrant_tracker] ERROR");
      $finish;
   end

endmodule

### files.f
design/epqt_pkg.sv
design/epqt_req_if.sv
design/epqt_rsp_if.sv
design/epqt_step.sv
design/endless_pot_quadrant_tracker.sv
bench/epqt_track_checker.sv
bench/tb_endless_pot_quadrant_tracker.sv
